@@ rtl/tmlc_pkg.sv @@
`default_nettype none

package tmlc_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 5;
    localparam int EVENT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Default maximum and minimum of the burst length, and the count trimmed
    localparam int TMLC_MAX_SAMPLES = 16;
    localparam int MIN_COUNT        = 3;
    localparam int TRIM_COUNT       = 2;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 12'd2048;
    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 12'd1024;
    localparam logic [SAMPLE_W-1:0] RISE_REFERENCE_RST = 12'd1024;
    localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RST   = 5'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_THRESHOLD = 2'd0,
        CFG_LOW_THRESHOLD  = 2'd1,
        CFG_RISE_REFERENCE = 2'd2,
        CFG_SAMPLE_COUNT   = 2'd3
    } cfg_index_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_HOLD = 2'd0,
        EV_RISE = 2'd1,
        EV_FALL = 2'd2
    } light_event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REPORT
    } tmlc_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                suppress;
    } tmlc_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        light_event_t        light_event;
        logic                is_bright;
    } tmlc_out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic publish;
    } tmlc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_sample;
        logic div_last;
        logic out_busy;
    } tmlc_status_t;

endpackage

`default_nettype wire

@@ rtl/tmlc_stream_if.sv @@
`default_nettype none

interface tmlc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tmlc_ctrl.sv @@
`default_nettype none

module tmlc_ctrl
    import tmlc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire tmlc_status_t status,
    output tmlc_cmd_t         cmd
);

    tmlc_state_t state_reg;
    tmlc_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence accumulate, divide and report
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.last_sample)
                    begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tmlc_datapath.sv @@
`default_nettype none

module tmlc_datapath
    import tmlc_pkg::*;
#(
    parameter int MAX_SAMPLES = TMLC_MAX_SAMPLES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tmlc_cmd_t             cmd,
    output tmlc_status_t               status,
    input  wire logic [SAMPLE_W-1:0]   sample,
    input  wire logic                  suppress,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output tmlc_out_t                  out_word
);

    localparam int NW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = $clog2(MAX_SAMPLES * ((1 << SAMPLE_W) - 1) + 1);
    localparam int DW = $clog2(MAX_SAMPLES - 1);
    localparam int KW = $clog2(SW);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

    // Configuration registers
    logic [SAMPLE_W-1:0] high_threshold_reg;
    logic [SAMPLE_W-1:0] low_threshold_reg;
    logic [SAMPLE_W-1:0] rise_reference_reg;
    logic [COUNT_W-1:0]  sample_count_reg;

    // Burst accumulators
    logic [SW-1:0]       sum_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] min_reg;
    logic [NW-1:0]       cnt_reg;

    // Classifier state
    logic [SAMPLE_W-1:0] prev_reg;
    light_event_t        event_reg;
    logic                bright_reg;
    logic                suppress_reg;

    // Divider
    logic [SW-1:0]       num_reg;
    logic [DW-1:0]       rem_reg;
    logic [DW-1:0]       divisor_reg;
    logic [KW-1:0]       step_reg;

    // Output word
    logic                out_valid_reg;
    tmlc_out_t           out_reg;

    logic [SW-1:0]       sum_next;
    logic [SAMPLE_W-1:0] max_next;
    logic [SAMPLE_W-1:0] min_next;
    logic [NW-1:0]       cnt_next;
    logic [SW-1:0]       trimmed;
    logic [CW-1:0]       count_ext;
    logic [CW-1:0]       count_sel;
    logic [NW-1:0]       count_eff;
    logic [NW-1:0]       divisor_full;
    logic                last_sample;
    logic [DW:0]         partial;
    logic [DW:0]         partial_diff;
    logic                quot_bit;
    logic [SAMPLE_W-1:0] mean;
    light_event_t        event_next;
    logic                bright_next;

    // Clamp the burst length into its legal range
    always_comb
    begin
        count_ext = CW'(sample_count_reg);
        if (count_ext < CW'(MIN_COUNT))
        begin
            count_sel = CW'(MIN_COUNT);
        end
        else if (count_ext > CW'(MAX_SAMPLES))
        begin
            count_sel = CW'(MAX_SAMPLES);
        end
        else
        begin
            count_sel = count_ext;
        end
        count_eff    = count_sel[NW-1:0];
        divisor_full = count_eff - NW'(TRIM_COUNT);
    end

    // Fold the new sample into the burst
    always_comb
    begin
        sum_next    = sum_reg + SW'(sample);
        max_next    = (sample > max_reg) ? sample : max_reg;
        min_next    = (sample < min_reg) ? sample : min_reg;
        cnt_next    = cnt_reg + NW'(1);
        last_sample = (cnt_next >= count_eff);
        trimmed     = sum_next - SW'(max_next) - SW'(min_next);
    end

    // One restoring division step
    always_comb
    begin
        partial      = {rem_reg, num_reg[SW-1]};
        partial_diff = partial - {1'b0, divisor_reg};
        quot_bit     = (partial >= {1'b0, divisor_reg});
    end

    // Classify the mean with hysteresis
    always_comb
    begin
        mean        = num_reg[SAMPLE_W-1:0];
        event_next  = event_reg;
        bright_next = bright_reg;
        if (mean > high_threshold_reg)
        begin
            bright_next = 1'b1;
            event_next  = (prev_reg <= rise_reference_reg) ? EV_RISE : EV_HOLD;
        end
        else if (mean < low_threshold_reg)
        begin
            bright_next = 1'b0;
            event_next  = (prev_reg >= high_threshold_reg) ? EV_FALL : EV_HOLD;
        end
        if (suppress_reg)
        begin
            event_next = EV_HOLD;
        end
    end

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_threshold_reg <= HIGH_THRESHOLD_RST;
            low_threshold_reg  <= LOW_THRESHOLD_RST;
            rise_reference_reg <= RISE_REFERENCE_RST;
            sample_count_reg   <= SAMPLE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HIGH_THRESHOLD: high_threshold_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_RISE_REFERENCE: rise_reference_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_SAMPLE_COUNT:   sample_count_reg   <= cfg_data[COUNT_W-1:0];
                default:            sample_count_reg   <= sample_count_reg;
            endcase
        end
    end

    // Accumulate; clear at the end of a burst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            max_reg <= '0;
            min_reg <= '1;
            cnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_sample)
            begin
                sum_reg <= '0;
                max_reg <= '0;
                min_reg <= '1;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                max_reg <= max_next;
                min_reg <= min_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Load and advance the divider
    always_ff @(posedge clk)
    begin
        if (cmd.accept && last_sample)
        begin
            num_reg      <= trimmed;
            rem_reg      <= '0;
            divisor_reg  <= divisor_full[DW-1:0];
            suppress_reg <= suppress;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[SW-2:0], quot_bit};
            rem_reg <= quot_bit ? partial_diff[DW-1:0] : partial[DW-1:0];
        end
    end

    // Count division steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.accept && last_sample)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + KW'(1);
        end
    end

    // Update classifier state on publish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            event_reg  <= EV_HOLD;
            bright_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            prev_reg   <= mean;
            event_reg  <= event_next;
            bright_reg <= bright_next;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_reg.average     <= mean;
            out_reg.light_event <= event_next;
            out_reg.is_bright   <= bright_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_word           = out_reg;
    assign status.last_sample = last_sample;
    assign status.div_last    = (step_reg == KW'(SW - 1));
    assign status.out_busy    = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

@@ rtl/trimmed_mean_light_classifier.sv @@
`default_nettype none

// Trimmed-mean light classifier. Light samples arrive as words on the
// reading channel; after sample_count of them (clamped to 3..MAX_SAMPLES)
// the block drops the largest and smallest, averages the rest and
// classifies the mean against the high and low thresholds with hysteresis,
// giving one word on the report channel (mean, event, bright flag). A
// sample that does not end a burst is taken in the idle state, so samples may
// stream back to back. The final sample starts a bit-serial restoring
// divider that works through each bit of the running sum, then the block
// publishes the report. The reading channel is not ready while dividing,
// nor while a finished report still waits to be taken and the next one is
// ready to go out. Registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them between bursts, as the block does
// not enforce it.
module trimmed_mean_light_classifier
    import tmlc_pkg::*;
#(
    parameter int MAX_SAMPLES = TMLC_MAX_SAMPLES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tmlc_stream_if.sink                reading,
    tmlc_stream_if.source              report,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    tmlc_cmd_t    cmd;
    tmlc_status_t status;
    tmlc_in_t     in_word;
    tmlc_out_t    out_word;
    logic         in_ready;
    logic         out_valid;

    assign in_word       = reading.data;
    assign reading.ready = in_ready;
    assign report.valid  = out_valid;
    assign report.data   = out_word;

    tmlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (reading.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tmlc_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (in_word.sample),
        .suppress  (in_word.suppress),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (report.ready),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

@@ rtl/tmlc_checker.sv @@
`default_nettype none

module tmlc_checker
    import tmlc_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         out_valid,
    input wire logic         out_ready,
    input wire logic [EVENT_W-1:0] out_event,
    input wire logic         out_bright,
    input wire logic [SAMPLE_W-1:0] out_average
);

    // A stalled report word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_average)
            && $stable(out_event) && $stable(out_bright))
        else $error("report word changed while stalled");

    // A rise goes with the bright flag set
    a_rise_bright: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_event == EV_RISE) |-> out_bright)
        else $error("rise reported without bright flag");

    // A fall goes with the bright flag clear
    a_fall_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_event == EV_FALL) |-> !out_bright)
        else $error("fall reported with bright flag");

endmodule

bind trimmed_mean_light_classifier tmlc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (report.valid),
    .out_ready   (report.ready),
    .out_event   (report.data.light_event),
    .out_bright  (report.data.is_bright),
    .out_average (report.data.average)
);

`default_nettype wire

@@ tb/trimmed_mean_light_classifier_tb.sv @@
module trimmed_mean_light_classifier_tb;
    import tmlc_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int WORDS_PER_PHASE = 150;
    localparam int PRESSURE_WORDS  = 130;
    localparam int SAMPLE_MAX      = 4095;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tmlc_stream_if #(.payload_t(tmlc_in_t))  reading_if ();
    tmlc_stream_if #(.payload_t(tmlc_out_t)) report_if ();

    trimmed_mean_light_classifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .reading   (reading_if),
        .report    (report_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Traffic control and bookkeeping
    tmlc_in_t  pending_words[$];
    tmlc_out_t expected_reports[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_busy = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   errors = 0;
    int   words_sent = 0;
    int   reports_checked = 0;
    int   rises_seen = 0;
    int   falls_seen = 0;
    int   settings_applied = 0;

    // Shadow of the block: registers and burst state
    logic [SAMPLE_W-1:0] hi_thr;
    logic [SAMPLE_W-1:0] lo_thr;
    logic [SAMPLE_W-1:0] rise_ref;
    logic [COUNT_W-1:0]  burst_len_reg;
    int unsigned         burst_sum;
    logic [SAMPLE_W-1:0] burst_peak;
    logic [SAMPLE_W-1:0] burst_trough;
    int unsigned         burst_taken;
    logic [SAMPLE_W-1:0] last_mean;
    light_event_t        held_event;
    logic                bright;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned burst_length();
        if (burst_len_reg < MIN_COUNT)
            return MIN_COUNT;
        if (burst_len_reg > TMLC_MAX_SAMPLES)
            return TMLC_MAX_SAMPLES;
        return burst_len_reg;
    endfunction

    // Fold one accepted word into the burst; queue a report when the burst ends
    function automatic void fold_sample(input tmlc_in_t w);
        int unsigned eff;
        int unsigned quotient;
        tmlc_out_t   r;
        eff = burst_length();
        burst_sum += w.sample;
        if (w.sample > burst_peak)
            burst_peak = w.sample;
        if (w.sample < burst_trough)
            burst_trough = w.sample;
        if (burst_taken < 63)
            burst_taken++;
        if (burst_taken < eff)
            return;
        quotient = (burst_sum - burst_peak - burst_trough) / (eff - TRIM_COUNT);
        r.average = quotient[SAMPLE_W-1:0];
        // High test first, so crossed thresholds count as bright
        if (r.average > hi_thr)
        begin
            bright = 1'b1;
            held_event = (last_mean <= rise_ref) ? EV_RISE : EV_HOLD;
        end
        else if (r.average < lo_thr)
        begin
            bright = 1'b0;
            held_event = (last_mean >= hi_thr) ? EV_FALL : EV_HOLD;
        end
        if (w.suppress)
            held_event = EV_HOLD;
        last_mean = r.average;
        r.light_event = held_event;
        r.is_bright = bright;
        expected_reports.push_back(r);
        burst_sum = 0;
        burst_peak = '0;
        burst_trough = '1;
        burst_taken = 0;
    endfunction

    task automatic check_report(input tmlc_out_t got);
        tmlc_out_t want;
        reports_checked++;
        if (got.light_event == EV_RISE)
            rises_seen++;
        if (got.light_event == EV_FALL)
            falls_seen++;
        if (expected_reports.size() == 0)
        begin
            if (errors < 10)
                $display("unexpected report: average %0d event %0d bright %0d",
                         got.average, got.light_event, got.is_bright);
            errors++;
            return;
        end
        want = expected_reports.pop_front();
        if (got.average !== want.average || got.light_event !== want.light_event
            || got.is_bright !== want.is_bright)
        begin
            if (errors < 10)
                $display("report %0d: average %0d/%0d event %0d/%0d bright %0d/%0d (exp/got)",
                         reports_checked, want.average, got.average, want.light_event,
                         got.light_event, want.is_bright, got.is_bright);
            errors++;
        end
    endtask

    // Offer queued words; hold each until taken
    always @(posedge clk)
    begin : drive_readings
        logic offer;
        if (!rst_n)
            reading_if.valid <= 1'b0;
        else
        begin
            offer = reading_if.valid;
            if (reading_if.valid && reading_if.ready)
            begin
                fold_sample(reading_if.data);
                void'(pending_words.pop_front());
                words_sent++;
                offer = 1'b0;
            end
            if (!offer && pending_words.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                reading_if.valid <= 1'b1;
                reading_if.data  <= pending_words[0];
            end
            else
                reading_if.valid <= offer;
        end
    end

    // Take reports, stalling at random or during a hold-off
    always @(posedge clk)
    begin : watch_reports
        if (!rst_n)
            report_if.ready <= 1'b0;
        else
        begin
            if (report_if.valid && report_if.ready)
                check_report(report_if.data);
            report_if.ready <= !hold_busy && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin : hold_off
        if (hold_req && !hold_busy)
        begin
            hold_busy <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_busy)
        begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_busy <= 1'b0;
        end
    end

    // Abort when no word moves for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (reading_if.valid && reading_if.ready)
            || (report_if.valid && report_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Wait until every word is taken and every report has arrived
    task automatic drain();
        while (pending_words.size() != 0 || reading_if.valid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic quiesce();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_HIGH_THRESHOLD: hi_thr = val;
            CFG_LOW_THRESHOLD:  lo_thr = val;
            CFG_RISE_REFERENCE: rise_ref = val;
            CFG_SAMPLE_COUNT:   burst_len_reg = val[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int hi, input int lo, input int rr, input int cnt);
        quiesce();
        write_reg(CFG_HIGH_THRESHOLD, hi[CFG_DATA_W-1:0]);
        write_reg(CFG_LOW_THRESHOLD, lo[CFG_DATA_W-1:0]);
        write_reg(CFG_RISE_REFERENCE, rr[CFG_DATA_W-1:0]);
        write_reg(CFG_SAMPLE_COUNT, cnt[CFG_DATA_W-1:0]);
        settings_applied++;
    endtask

    task automatic push_word(input int s, input logic sup);
        tmlc_in_t w;
        w.sample   = s[SAMPLE_W-1:0];
        w.suppress = sup;
        pending_words.push_back(w);
    endtask

    // Bursts around a random level, with outliers and extremes mixed in
    task automatic queue_random_words(input int count);
        int eff;
        int pos;
        int level;
        int spread;
        int pick;
        int s;
        eff = burst_length();
        pos = 0;
        level = 0;
        spread = 0;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            if (pos == 0)
            begin
                level = $urandom_range(0, SAMPLE_MAX);
                case ($urandom_range(0, 3))
                    0: spread = 0;
                    1: spread = 15;
                    2: spread = 255;
                    default: spread = SAMPLE_MAX;
                endcase
            end
            pick = $urandom_range(0, 15);
            if (pick == 0)
                s = 0;
            else if (pick == 1)
                s = SAMPLE_MAX;
            else if (pick < 4)
                s = $urandom_range(0, SAMPLE_MAX);
            else
                s = level + int'($urandom_range(0, 2 * spread)) - spread;
            if (s < 0)
                s = 0;
            if (s > SAMPLE_MAX)
                s = SAMPLE_MAX;
            push_word(s, $urandom_range(0, 3) == 0);
            pos = (pos + 1 == eff) ? 0 : pos + 1;
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    initial
    begin : run
        int hi;
        int lo;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HIGH_THRESHOLD;
        cfg_data = '0;
        reading_if.valid = 1'b0;
        reading_if.data = '0;
        report_if.ready = 1'b0;
        hi_thr = HIGH_THRESHOLD_RST;
        lo_thr = LOW_THRESHOLD_RST;
        rise_ref = RISE_REFERENCE_RST;
        burst_len_reg = SAMPLE_COUNT_RST;
        burst_sum = 0;
        burst_peak = '0;
        burst_trough = '1;
        burst_taken = 0;
        last_mean = '0;
        held_event = EV_HOLD;
        bright = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Shortest burst via a zero count; rise, fall, then suppressed hold
        write_reg(CFG_SAMPLE_COUNT, '0);
        @(negedge clk);
        push_word(SAMPLE_MAX, 1'b1);
        push_word(SAMPLE_MAX, 1'b0);
        push_word(SAMPLE_MAX, 1'b0);
        push_word(0, 1'b0);
        push_word(0, 1'b0);
        push_word(0, 1'b0);
        push_word(0, 1'b0);
        push_word(SAMPLE_MAX, 1'b0);
        push_word(2000, 1'b1);

        // Crossed thresholds: bright wins, then a fall from it
        configure(100, 3000, 0, 2);
        @(negedge clk);
        push_word(500, 1'b0);
        push_word(500, 1'b0);
        push_word(500, 1'b0);
        push_word(50, 1'b0);
        push_word(60, 1'b0);
        push_word(70, 1'b0);

        // Shorten the burst while it is partly filled; mean wraps to 12 bits
        configure(2048, 1024, 1024, 5);
        @(negedge clk);
        repeat (4) push_word(SAMPLE_MAX, 1'b0);
        quiesce();
        write_reg(CFG_SAMPLE_COUNT, 3);
        @(negedge clk);
        push_word(SAMPLE_MAX, 1'b0);

        // Random phases, each under its own settings and idling
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: configure(2048, 1024, 1024, 10);
                1: configure(SAMPLE_MAX, 0, 0, 31);
                2: configure(0, SAMPLE_MAX, SAMPLE_MAX, 1);
                3: configure(3000, 500, 2000, 17);
                4: configure(1, 0, SAMPLE_MAX, 16);
                default:
                begin
                    hi = $urandom_range(0, SAMPLE_MAX);
                    lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SAMPLE_MAX)
                                                     : $urandom_range(0, hi);
                    configure(hi, lo, $urandom_range(0, SAMPLE_MAX),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(3, 6));
                end
            endcase
            set_idling(p % 4);
            queue_random_words(WORDS_PER_PHASE);
        end

        // Receiver holds off while the sender keeps offering
        configure(1500, 800, 1000, 3);
        set_idling(0);
        queue_random_words(PRESSURE_WORDS);
        @(posedge clk);
        hold_req <= 1'b1;
        while (!hold_busy)
            @(posedge clk);
        hold_req <= 1'b0;
        while (hold_busy)
            @(posedge clk);

        quiesce();
        errors += expected_reports.size();
        $display("%0d samples over %0d register settings, %0d reports checked",
                 words_sent, settings_applied, reports_checked);
        $display("%0d rise and %0d fall events seen, %0d mismatches",
                 rises_seen, falls_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
